[src/touch_gesture_classifier_top_assert.svh]
// Assertion macros shared by the touch gesture classifier RTL.
// Each macro expands to one labeled concurrent assertion on a clock and an active-low reset.
`ifndef TOUCH_GESTURE_CLASSIFIER_TOP_ASSERT_SVH
`define TOUCH_GESTURE_CLASSIFIER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TGC_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("touch gesture classifier check failed");

// The consequent must hold in the cycle after the antecedent.
`define TGC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("touch gesture classifier check failed");

`endif

[src/tgc_pkg.sv]
// Package for the touch gesture classifier: widths, codes, state and result types,
// and the saturation and magnitude helpers. No dependencies.
`default_nettype none

package tgc_pkg;

    localparam int COORD_BITS = 12;
    localparam int MOVE_BITS  = 16;

    localparam int DEB_W   = 8;
    localparam int REL_W   = DEB_W + 1;
    localparam int PRESS_W = 16;
    localparam int THR_W   = 15;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 3;

    localparam int SUM_W = ((MOVE_BITS > COORD_BITS + 1) ? MOVE_BITS : COORD_BITS + 1) + 1;
    localparam int ABS_W = (MOVE_BITS + 1 > THR_W) ? MOVE_BITS + 1 : THR_W;

    localparam logic signed [SUM_W-1:0] MOVE_MAX = SUM_W'((2 ** (MOVE_BITS - 1)) - 1);
    localparam logic signed [SUM_W-1:0] MOVE_MIN = SUM_W'(-(2 ** (MOVE_BITS - 1)));

    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_DEBOUNCE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_COUNT_LIMIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_MIN_TICKS     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_MAX_TICKS     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MOVE_THRESHOLD    = 3'd4;

    localparam logic [DEB_W-1:0]   RELEASE_DEBOUNCE_RST  = 8'd4;
    localparam logic [PRESS_W-1:0] PRESS_COUNT_LIMIT_RST = 16'd1000;
    localparam logic [PRESS_W-1:0] TAP_MIN_TICKS_RST     = 16'd2;
    localparam logic [PRESS_W-1:0] TAP_MAX_TICKS_RST     = 16'd50;
    localparam logic [THR_W-1:0]   MOVE_THRESHOLD_RST    = 15'd20;

    typedef enum logic [1:0] {
        FUNC_TICK  = 2'd0,
        FUNC_READ  = 2'd1,
        FUNC_CLEAR = 2'd2,
        FUNC_PEEK  = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        GEST_OFF  = 3'd0,
        GEST_ON   = 3'd1,
        GEST_LONG = 3'd2,
        GEST_DRAG = 3'd3,
        GEST_TAP  = 3'd4
    } gesture_t;

    typedef struct packed {
        logic [DEB_W-1:0]   release_debounce;
        logic [PRESS_W-1:0] press_count_limit;
        logic [PRESS_W-1:0] tap_min_ticks;
        logic [PRESS_W-1:0] tap_max_ticks;
        logic [THR_W-1:0]   move_threshold;
    } tgc_cfg_t;

    typedef struct packed {
        logic [DEB_W-1:0]            filter_off_count;
        logic [REL_W-1:0]            release_count;
        logic [PRESS_W-1:0]          press_count;
        logic                        moved_flag;
        logic [COORD_BITS-1:0]       cur_x;
        logic [COORD_BITS-1:0]       cur_y;
        logic [COORD_BITS-1:0]       last_x;
        logic [COORD_BITS-1:0]       last_y;
        logic signed [MOVE_BITS-1:0] sum_x;
        logic signed [MOVE_BITS-1:0] sum_y;
        gesture_t                    held_gesture;
    } tgc_state_t;

    typedef struct packed {
        gesture_t                    gesture;
        logic                        touch_active;
        logic signed [MOVE_BITS-1:0] move_x;
        logic signed [MOVE_BITS-1:0] move_y;
    } tgc_result_t;

    localparam tgc_cfg_t CFG_RESET = '{
        release_debounce:  RELEASE_DEBOUNCE_RST,
        press_count_limit: PRESS_COUNT_LIMIT_RST,
        tap_min_ticks:     TAP_MIN_TICKS_RST,
        tap_max_ticks:     TAP_MAX_TICKS_RST,
        move_threshold:    MOVE_THRESHOLD_RST
    };

    localparam tgc_state_t STATE_RESET = '{
        filter_off_count: RELEASE_DEBOUNCE_RST,
        release_count:    REL_W'(RELEASE_DEBOUNCE_RST),
        press_count:      '0,
        moved_flag:       1'b0,
        cur_x:            '0,
        cur_y:            '0,
        last_x:           '0,
        last_y:           '0,
        sum_x:            '0,
        sum_y:            '0,
        held_gesture:     GEST_OFF
    };

    // Clamp a widened sum to the signed movement range.
    function automatic logic signed [MOVE_BITS-1:0] sat_move(input logic signed [SUM_W-1:0] v);
        if (v > MOVE_MAX) begin
            return MOVE_MAX[MOVE_BITS-1:0];
        end else if (v < MOVE_MIN) begin
            return MOVE_MIN[MOVE_BITS-1:0];
        end
        return v[MOVE_BITS-1:0];
    endfunction

    // Magnitude of a movement sum, wide enough for the most negative value.
    function automatic logic [ABS_W-1:0] abs_move(input logic signed [MOVE_BITS-1:0] v);
        logic signed [ABS_W:0] e;
        e = (ABS_W + 1)'(v);
        if (e < 0) begin
            e = -e;
        end
        return e[ABS_W-1:0];
    endfunction

endpackage

`default_nettype wire

[src/tgc_core.sv]
// Combinational next-state and result logic of the touch gesture classifier for one item.
// Depends on tgc_pkg for widths, codes and the state, configuration and result types.
`default_nettype none

module tgc_core (
    input  var tgc_pkg::tgc_cfg_t      cfg,
    input  var tgc_pkg::tgc_state_t    state,
    input  wire logic [1:0]            func,
    input  wire logic                  touch_present,
    input  wire logic [tgc_pkg::COORD_BITS-1:0] pos_x,
    input  wire logic [tgc_pkg::COORD_BITS-1:0] pos_y,
    output tgc_pkg::tgc_state_t        state_next,
    output tgc_pkg::tgc_result_t       result
);

    logic [tgc_pkg::DEB_W-1:0]   foc_t;
    logic                        on;
    logic [tgc_pkg::COORD_BITS-1:0] cx;
    logic [tgc_pkg::COORD_BITS-1:0] cy;
    logic                        touchdown;
    logic [tgc_pkg::REL_W:0]     rc_inc;
    logic [tgc_pkg::REL_W-1:0]   rc_t;
    logic                        moved_b;
    logic [tgc_pkg::PRESS_W-1:0] press_b;
    logic [tgc_pkg::PRESS_W-1:0] press_t;
    logic signed [tgc_pkg::MOVE_BITS-1:0] sum_bx;
    logic signed [tgc_pkg::MOVE_BITS-1:0] sum_by;
    logic [tgc_pkg::COORD_BITS-1:0] last_bx;
    logic [tgc_pkg::COORD_BITS-1:0] last_by;
    logic                        do_add;
    logic signed [tgc_pkg::COORD_BITS:0] dx;
    logic signed [tgc_pkg::COORD_BITS:0] dy;
    logic signed [tgc_pkg::MOVE_BITS-1:0] sx_t;
    logic signed [tgc_pkg::MOVE_BITS-1:0] sy_t;
    logic                        small_move;
    logic                        is_tap;
    tgc_pkg::gesture_t           gest_t;
    logic [tgc_pkg::REL_W-1:0]   deb_ext;

    assign deb_ext = tgc_pkg::REL_W'(cfg.release_debounce);

    // Release filter: the absent-sample count saturates at the debounce setting.
    always_comb begin
        if (touch_present) begin
            foc_t = '0;
        end else if (state.filter_off_count < cfg.release_debounce) begin
            foc_t = state.filter_off_count + 1'b1;
        end else begin
            foc_t = cfg.release_debounce;
        end
    end

    assign on = touch_present || (foc_t < cfg.release_debounce);
    assign cx = touch_present ? pos_x : state.cur_x;
    assign cy = touch_present ? pos_y : state.cur_y;

    assign touchdown = on && (state.release_count >= deb_ext);
    assign rc_inc    = (tgc_pkg::REL_W + 1)'(state.release_count) + 1'b1;

    always_comb begin
        if (on) begin
            rc_t = '0;
        end else if (rc_inc >= (tgc_pkg::REL_W + 1)'(cfg.release_debounce)) begin
            rc_t = deb_ext + 1'b1;
        end else begin
            rc_t = rc_inc[tgc_pkg::REL_W-1:0];
        end
    end

    assign moved_b = touchdown ? 1'b0 : state.moved_flag;
    assign press_b = touchdown ? '0 : state.press_count;
    assign sum_bx  = touchdown ? '0 : state.sum_x;
    assign sum_by  = touchdown ? '0 : state.sum_y;
    assign last_bx = touchdown ? '0 : state.last_x;
    assign last_by = touchdown ? '0 : state.last_y;

    always_comb begin
        if (on && (press_b < cfg.press_count_limit)) begin
            press_t = press_b + 1'b1;
        end else begin
            press_t = press_b;
        end
    end

    // Movement is only added once a previous point with nonzero coordinates exists.
    assign do_add = on && (last_bx != '0) && (last_by != '0);
    assign dx = $signed({1'b0, cx}) - $signed({1'b0, last_bx});
    assign dy = $signed({1'b0, cy}) - $signed({1'b0, last_by});

    assign sx_t = do_add ? tgc_pkg::sat_move(tgc_pkg::SUM_W'(sum_bx) + tgc_pkg::SUM_W'(dx))
                         : sum_bx;
    assign sy_t = do_add ? tgc_pkg::sat_move(tgc_pkg::SUM_W'(sum_by) + tgc_pkg::SUM_W'(dy))
                         : sum_by;

    assign small_move = (tgc_pkg::abs_move(sx_t) < tgc_pkg::ABS_W'(cfg.move_threshold)) &&
                        (tgc_pkg::abs_move(sy_t) < tgc_pkg::ABS_W'(cfg.move_threshold));

    assign is_tap = !on && small_move && !moved_b &&
                    (press_t >= cfg.tap_min_ticks) && (press_t <= cfg.tap_max_ticks) &&
                    (rc_t >= deb_ext);

    always_comb begin
        if (on) begin
            if (small_move && !moved_b) begin
                gest_t = (press_t > cfg.tap_max_ticks) ? tgc_pkg::GEST_LONG : tgc_pkg::GEST_ON;
            end else begin
                gest_t = tgc_pkg::GEST_DRAG;
            end
        end else if (is_tap) begin
            gest_t = tgc_pkg::GEST_TAP;
        end else begin
            gest_t = state.held_gesture;
        end
    end

    always_comb begin
        state_next          = state;
        result.gesture      = state.held_gesture;
        result.touch_active = 1'b0;
        result.move_x       = state.sum_x;
        result.move_y       = state.sum_y;
        case (func)
            tgc_pkg::FUNC_TICK: begin
                state_next.filter_off_count = foc_t;
                state_next.release_count    = rc_t;
                state_next.press_count      = is_tap ? '0 : press_t;
                state_next.moved_flag       = moved_b || !small_move;
                state_next.cur_x            = cx;
                state_next.cur_y            = cy;
                state_next.last_x           = on ? cx : state.last_x;
                state_next.last_y           = on ? cy : state.last_y;
                state_next.sum_x            = sx_t;
                state_next.sum_y            = sy_t;
                state_next.held_gesture     = gest_t;
                result.gesture              = gest_t;
                result.touch_active         = on;
                result.move_x               = sx_t;
                result.move_y               = sy_t;
            end
            tgc_pkg::FUNC_READ: begin
                state_next.held_gesture = tgc_pkg::GEST_OFF;
            end
            tgc_pkg::FUNC_CLEAR: begin
                state_next.sum_x = '0;
                state_next.sum_y = '0;
                result.move_x    = '0;
                result.move_y    = '0;
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

[src/touch_gesture_classifier_top.sv]
// Touch gesture classifier top level: configuration registers, state and result registers.
// Depends on tgc_pkg, tgc_core and touch_gesture_classifier_top_assert.svh.
//
// Usage: each item on the s_ channel is a sample tick, a read-and-clear of the held
// gesture, a clear of the accumulated movement or a peek, selected by s_func. Every item
// yields exactly one result item on the m_ channel with the gesture, the debounced
// touch state (low for all but a tick) and the saturated x and y movement.
// An accepted item is registered and shown on m_ in the cycle after it is accepted.
// Throughput is one item per cycle while the receiver does not stall, set by the single
// state update between the state registers and the result register.
// When the receiver stalls, the result register holds its item and s_ready stays
// high only if that item is taken in the same cycle.
// Configuration registers are written through cfg_wr_en, cfg_index and cfg_wr_data,
// and take effect for the next item; write them only while idle (not enforced here).
// Reset (aresetn low at a clock edge) restores register defaults, clears the press count
// and movement, sets the held gesture to off and empties the result register.
`default_nettype none

module touch_gesture_classifier_top (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_wr_en,
    input  wire logic [tgc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [tgc_pkg::CFG_W-1:0]           cfg_wr_data,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [1:0]                          s_func,
    input  wire logic                                s_touch_present,
    input  wire logic [tgc_pkg::COORD_BITS-1:0]      s_pos_x,
    input  wire logic [tgc_pkg::COORD_BITS-1:0]      s_pos_y,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic [2:0]                               m_gesture,
    output logic                                     m_touch_active,
    output logic signed [tgc_pkg::MOVE_BITS-1:0]     m_move_x,
    output logic signed [tgc_pkg::MOVE_BITS-1:0]     m_move_y
);

    `include "touch_gesture_classifier_top_assert.svh"

    tgc_pkg::tgc_cfg_t    cfg_reg;
    tgc_pkg::tgc_cfg_t    cfg_next;
    tgc_pkg::tgc_state_t  state_reg;
    tgc_pkg::tgc_state_t  state_next;
    tgc_pkg::tgc_result_t result_reg;
    tgc_pkg::tgc_result_t result_next;
    logic                 m_valid_reg;
    logic                 m_valid_next;
    logic                 accept;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                tgc_pkg::CFG_RELEASE_DEBOUNCE: begin
                    cfg_next.release_debounce = cfg_wr_data[tgc_pkg::DEB_W-1:0];
                end
                tgc_pkg::CFG_PRESS_COUNT_LIMIT: begin
                    cfg_next.press_count_limit = cfg_wr_data[tgc_pkg::PRESS_W-1:0];
                end
                tgc_pkg::CFG_TAP_MIN_TICKS: begin
                    cfg_next.tap_min_ticks = cfg_wr_data[tgc_pkg::PRESS_W-1:0];
                end
                tgc_pkg::CFG_TAP_MAX_TICKS: begin
                    cfg_next.tap_max_ticks = cfg_wr_data[tgc_pkg::PRESS_W-1:0];
                end
                tgc_pkg::CFG_MOVE_THRESHOLD: begin
                    cfg_next.move_threshold = cfg_wr_data[tgc_pkg::THR_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    tgc_core u_core (
        .cfg           (cfg_reg),
        .state         (state_reg),
        .func          (s_func),
        .touch_present (s_touch_present),
        .pos_x         (s_pos_x),
        .pos_y         (s_pos_y),
        .state_next    (state_next),
        .result        (result_next)
    );

    assign s_ready      = !m_valid_reg || m_ready;
    assign accept       = s_valid && s_ready;
    assign m_valid_next = accept || (m_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg     <= tgc_pkg::CFG_RESET;
            state_reg   <= tgc_pkg::STATE_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            cfg_reg     <= cfg_next;
            m_valid_reg <= m_valid_next;
            if (accept) begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            result_reg <= result_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_gesture      = result_reg.gesture;
    assign m_touch_active = result_reg.touch_active;
    assign m_move_x       = result_reg.move_x;
    assign m_move_y       = result_reg.move_y;

    `TGC_ASSERT_NEXT(a_read_clears_gesture, aclk, aresetn,
        accept && (s_func == tgc_pkg::FUNC_READ), state_reg.held_gesture == tgc_pkg::GEST_OFF)
    `TGC_ASSERT_NEXT(a_present_zeroes_release, aclk, aresetn,
        accept && (s_func == tgc_pkg::FUNC_TICK) && s_touch_present,
        (state_reg.release_count == '0) && m_touch_active)
    `TGC_ASSERT_SAME(a_active_gesture, aclk, aresetn, m_valid && m_touch_active,
        (m_gesture == tgc_pkg::GEST_ON) || (m_gesture == tgc_pkg::GEST_LONG) ||
        (m_gesture == tgc_pkg::GEST_DRAG))

endmodule

`default_nettype wire
